@@ src/seas_pkg.sv @@
// seas_pkg: widths, constants, state types and status structs for the
// spindle encoder speed and angle block
// no dependencies; used by the interfaces, seas_div and the top level
`default_nettype none

package seas_pkg;

    // field widths
    localparam int OP_W    = 1;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 15;
    localparam int REV_W   = 16;
    localparam int ANGLE_W = 32;
    localparam int EPR_W   = 11;
    localparam int COUNT_W = 32;

    // config port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;

    // datapath widths
    localparam int DENOM_W   = EPR_W + TIME_W;        // edges_per_rev * dt
    localparam int S3_W      = SPEED_W + 2;           // 3 * speed
    localparam int PROD_W    = S3_W + TIME_W;         // 3 * speed * dt
    localparam int SPD_DVD_W = 26;                    // holds 60e6
    localparam int FRAC_W    = 27;                    // 36000 * remainder
    localparam int MULC_W    = $clog2(EPR_W);
    localparam int D1_CNT_W  = $clog2(PROD_W + 1);
    localparam int D2_CNT_W  = $clog2(COUNT_W + 1);

    // constants
    localparam logic [SPD_DVD_W-1:0] RPM_NUM      = 26'd60000000;
    localparam logic [DENOM_W-1:0]   STALL_NUM    = 43'd2000000;
    localparam logic [DENOM_W-1:0]   INTERP_DIV   = 43'd5000;
    localparam logic [15:0]          CDEG_PER_REV = 16'd36000;
    localparam logic [SPEED_W-1:0]   SPEED_MAX    = 15'h7fff;
    localparam logic [EPR_W-1:0]     EPR_RESET    = 11'd1;

    // iteration counts of the serial dividers
    localparam logic [D1_CNT_W-1:0] SPD_ITERS  = D1_CNT_W'(SPD_DVD_W);
    localparam logic [D1_CNT_W-1:0] INT_ITERS  = D1_CNT_W'(PROD_W);
    localparam logic [D2_CNT_W-1:0] CNT_ITERS  = D2_CNT_W'(COUNT_W);
    localparam logic [D2_CNT_W-1:0] FRAC_ITERS = D2_CNT_W'(FRAC_W);

    // op codes
    localparam logic [OP_W-1:0] OP_EDGE  = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_EPR = '0;

    // main sequencer: speed and interpolation path
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_IMUL,
        S_ISTART,
        S_DIV1,
        S_FIN
    } state_t;

    // count path sequencer: revolutions and base angle
    typedef enum logic [1:0] {
        U_IDLE,
        U_CNT,
        U_FRAC,
        U_DONE
    } cnt_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

@@ src/seas_in_if.sv @@
// seas_in_if: input item channel (op, time_us) with valid/ready
// depends on seas_pkg
`default_nettype none

interface seas_in_if;
    import seas_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] time_us;

    modport source (output valid, output op, output time_us, input ready);
    modport sink   (input valid, input op, input time_us, output ready);
endinterface

`default_nettype wire

@@ src/seas_out_if.sv @@
// seas_out_if: result channel (speed_rpm, revolutions, angle_cdeg) with valid/ready
// depends on seas_pkg
`default_nettype none

interface seas_out_if;
    import seas_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed_rpm;
    logic [REV_W-1:0]   revolutions;
    logic [ANGLE_W-1:0] angle_cdeg;

    modport source (output valid, output speed_rpm, output revolutions,
                    output angle_cdeg, input ready);
    modport sink   (input valid, input speed_rpm, input revolutions,
                    input angle_cdeg, output ready);
endinterface

`default_nettype wire

@@ src/seas_div.sv @@
// seas_div: bit-serial restoring divider, one quotient bit per cycle
// depends on seas_pkg; a left-aligned dividend with iters < DVD_W gives
// its quotient in the low bits
`default_nettype none

module seas_div #(
    parameter int DVD_W = seas_pkg::COUNT_W,
    parameter int DVS_W = seas_pkg::EPR_W,
    parameter int CNT_W = $clog2(DVD_W + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [DVS_W-1:0]    divisor,
    input  logic [CNT_W-1:0]    iters,
    output seas_pkg::div_stat_t stat,
    output logic [DVD_W-1:0]    quotient,
    output logic [DVS_W-1:0]    remainder
);
    import seas_pkg::*;

    logic [DVD_W-1:0] shreg_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // partial remainder stays below the divisor, so the difference fits DVS_W
    assign trial = {rem_reg, shreg_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= iters;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shreg_reg <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shreg_reg <= {shreg_reg[DVD_W-2:0], fits};
            rem_reg   <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = shreg_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ src/spindle_encoder_speed_angle.sv @@
// spindle_encoder_speed_angle: period tachometer and angle estimator for a
// single-channel spindle encoder
// depends on seas_pkg, seas_in_if, seas_out_if and seas_div
//
// usage:
//   item   - valid/ready channel; op = edge (0) or status query (1), plus a
//            microsecond timestamp. one transfer per encoder edge or query
//   result - valid/ready channel; one result per item: speed in rpm, whole
//            revolutions and angle in centidegrees
//   apb    - edges_per_rev at byte address 0, writes only while idle;
//            zero is treated as one
// timing:
//   two bit-serial dividers run side by side: the count path (32 + 27
//   quotient bits for revolutions and base angle) and the speed path
//   (serial msb-first edges_per_rev * dt shift-add multiply, then 26 bits for 60e6 /
//   period on an edge, or a product register and 49 bits for the interpolation
//   divide by 5000 on a query)
//   an edge's result waits on the count path, a query's on the speed path;
//   one item is in flight at a time, and the next item is taken the cycle
//   after a result enters the output register; a stalled receiver holds
//   that register and only blocks the following item at its end
// reset:
//   edge count, last edge time and speed clear, edges_per_rev returns to 1
`default_nettype none

module spindle_encoder_speed_angle (
    input  logic                          clk,
    input  logic                          rst_n,
    seas_in_if.sink                       item,
    seas_out_if.source                    result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [seas_pkg::ADDR_W-1:0]   paddr,
    input  logic [seas_pkg::DATA_W-1:0]   pwdata,
    output logic [seas_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import seas_pkg::*;

    // architectural state
    logic [EPR_W-1:0]     epr_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [TIME_W-1:0]    last_reg;
    logic [SPEED_W-1:0]   speed_reg;

    // per-item working registers
    logic [OP_W-1:0]      op_reg;
    logic [TIME_W-1:0]    dt_reg;
    logic [DENOM_W-1:0]   acc_reg;
    logic [EPR_W-1:0]     esh_reg;
    logic [MULC_W-1:0]    mulc_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ANGLE_W-1:0]   interp_reg;
    logic [ANGLE_W-1:0]   base_reg;
    logic [REV_W-1:0]     rev_reg;

    // output register
    logic                 oval_reg;
    logic [SPEED_W-1:0]   ospeed_reg;
    logic [REV_W-1:0]     orev_reg;
    logic [ANGLE_W-1:0]   oangle_reg;

    state_t               state_reg;
    state_t               state_next;
    cnt_state_t           cstate_reg;
    cnt_state_t           cstate_next;

    logic                 item_acc;
    logic                 item_rdy;
    logic                 is_edge;
    logic                 load_out;
    logic [EPR_W-1:0]     epr_eff;
    logic [S3_W-1:0]      s3;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    logic                 d1_start;
    logic [PROD_W-1:0]    d1_dvd;
    logic [DENOM_W-1:0]   d1_dvs;
    logic [D1_CNT_W-1:0]  d1_iters;
    div_stat_t            d1_stat;
    logic [PROD_W-1:0]    d1_q;

    logic                 d2_start;
    logic [COUNT_W-1:0]   d2_dvd;
    logic [D2_CNT_W-1:0]  d2_iters;
    div_stat_t            d2_stat;
    logic [COUNT_W-1:0]   d2_q;
    logic [EPR_W-1:0]     d2_rem;
    logic [FRAC_W-1:0]    frac_num;

    // config port
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && (cfg_idx == REG_EPR);
    assign pready  = 1'b1;
    assign prdata  = (cfg_idx == REG_EPR) ? {{(DATA_W-EPR_W){1'b0}}, epr_reg} : '0;

    assign epr_eff  = (epr_reg == '0) ? EPR_W'(1) : epr_reg;
    assign item_acc = item.valid && item_rdy;
    assign is_edge  = (op_reg == OP_EDGE);
    assign s3       = S3_W'({speed_reg, 1'b0}) + S3_W'(speed_reg);

    assign count_next = (item_acc && item.op == OP_EDGE) ? count_reg + COUNT_W'(1)
                                                         : count_reg;

    // speed path: 60e6 / denom on an edge, 3*speed*dt / 5000 on a query
    assign d1_dvd   = is_edge ? {RPM_NUM, {(PROD_W-SPD_DVD_W){1'b0}}} : prod_reg;
    assign d1_dvs   = is_edge ? acc_reg : INTERP_DIV;
    assign d1_iters = is_edge ? SPD_ITERS : INT_ITERS;

    // count path: count / E, then 36000 * remainder / E
    assign frac_num = FRAC_W'(d2_rem) * FRAC_W'(CDEG_PER_REV);
    assign d2_dvd   = (cstate_reg == U_IDLE) ? count_next
                                             : {frac_num, {(COUNT_W-FRAC_W){1'b0}}};
    assign d2_iters = (cstate_reg == U_IDLE) ? CNT_ITERS : FRAC_ITERS;

    seas_div #(
        .DVD_W (PROD_W),
        .DVS_W (DENOM_W),
        .CNT_W (D1_CNT_W)
    ) u_div_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (d1_start),
        .dividend  (d1_dvd),
        .divisor   (d1_dvs),
        .iters     (d1_iters),
        .stat      (d1_stat),
        .quotient  (d1_q),
        .remainder ()
    );

    seas_div #(
        .DVD_W (COUNT_W),
        .DVS_W (EPR_W),
        .CNT_W (D2_CNT_W)
    ) u_div_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (d2_start),
        .dividend  (d2_dvd),
        .divisor   (epr_eff),
        .iters     (d2_iters),
        .stat      (d2_stat),
        .quotient  (d2_q),
        .remainder (d2_rem)
    );

    // main sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (item_acc)
                    state_next = S_MUL;
            S_MUL:
                if (mulc_reg == '0)
                    state_next = S_CHECK;
            S_CHECK:
                if (!is_edge)
                    state_next = S_IMUL;
                else if (dt_reg == '0)
                    state_next = S_FIN;
                else
                    state_next = S_DIV1;
            S_IMUL:
                state_next = S_ISTART;
            S_ISTART:
                state_next = S_DIV1;
            S_DIV1:
                if (d1_stat.done)
                    state_next = S_FIN;
            S_FIN:
                if (load_out)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // main sequencer: outputs
    always_comb
    begin
        item_rdy = 1'b0;
        d1_start = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
                item_rdy = 1'b1;
            S_CHECK:
                d1_start = is_edge && (dt_reg != '0);
            S_ISTART:
                d1_start = 1'b1;
            S_FIN:
                load_out = (cstate_reg == U_DONE) && (!oval_reg || result.ready);
            default:
                ;
        endcase
    end

    // count path sequencer: next state
    always_comb
    begin
        cstate_next = cstate_reg;
        unique case (cstate_reg)
            U_IDLE:
                if (item_acc)
                    cstate_next = U_CNT;
            U_CNT:
                if (d2_stat.done)
                    cstate_next = U_FRAC;
            U_FRAC:
                if (d2_stat.done)
                    cstate_next = U_DONE;
            U_DONE:
                if (load_out)
                    cstate_next = U_IDLE;
            default:
                cstate_next = U_IDLE;
        endcase
    end

    // count path sequencer: outputs
    always_comb
    begin
        d2_start = 1'b0;
        unique case (cstate_reg)
            U_IDLE:
                d2_start = item_acc;
            U_CNT:
                d2_start = d2_stat.done;
            default:
                ;
        endcase
    end

    assign item.ready = item_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cstate_reg <= U_IDLE;
            epr_reg    <= EPR_RESET;
            count_reg  <= '0;
            last_reg   <= '0;
            speed_reg  <= '0;
            oval_reg   <= 1'b0;
            mulc_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cstate_reg <= cstate_next;
            count_reg  <= count_next;

            if (cfg_wr)
                epr_reg <= pwdata[EPR_W-1:0];

            if (item_acc && item.op == OP_EDGE)
                last_reg <= item.time_us;

            if (item_acc)
                mulc_reg <= MULC_W'(EPR_W - 1);
            else if (state_reg == S_MUL)
                mulc_reg <= mulc_reg - MULC_W'(1);

            // zero interval saturates; a stalled spindle reads as stopped
            if (state_reg == S_CHECK)
            begin
                if (is_edge && dt_reg == '0)
                    speed_reg <= SPEED_MAX;
                else if (!is_edge && acc_reg > STALL_NUM)
                    speed_reg <= '0;
            end
            else if (state_reg == S_DIV1 && d1_stat.done && is_edge)
            begin
                speed_reg <= (|d1_q[PROD_W-1:SPEED_W]) ? SPEED_MAX : d1_q[SPEED_W-1:0];
            end

            if (load_out)
                oval_reg <= 1'b1;
            else if (result.ready)
                oval_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            op_reg  <= item.op;
            dt_reg  <= item.time_us - last_reg;
            acc_reg <= '0;
            esh_reg <= epr_eff;
        end
        else if (state_reg == S_MUL)
        begin
            // msb-first shift-add of edges_per_rev * dt
            acc_reg <= {acc_reg[DENOM_W-2:0], 1'b0}
                       + (esh_reg[EPR_W-1] ? DENOM_W'(dt_reg) : '0);
            esh_reg <= {esh_reg[EPR_W-2:0], 1'b0};
        end

        // an edge leaves no time since the last edge
        if (state_reg == S_CHECK && is_edge)
            interp_reg <= '0;
        else if (state_reg == S_DIV1 && d1_stat.done && !is_edge)
            interp_reg <= d1_q[ANGLE_W-1:0];

        if (state_reg == S_IMUL)
            prod_reg <= PROD_W'(s3) * PROD_W'(dt_reg);

        if (cstate_reg == U_CNT && d2_stat.done)
        begin
            rev_reg  <= d2_q[REV_W-1:0];
            base_reg <= d2_q * ANGLE_W'(CDEG_PER_REV);
        end
        else if (cstate_reg == U_FRAC && d2_stat.done)
        begin
            base_reg <= base_reg + d2_q;
        end

        if (load_out)
        begin
            ospeed_reg <= speed_reg;
            orev_reg   <= rev_reg;
            oangle_reg <= base_reg + interp_reg;
        end
    end

    assign result.valid       = oval_reg;
    assign result.speed_rpm   = ospeed_reg;
    assign result.revolutions = orev_reg;
    assign result.angle_cdeg  = oangle_reg;

    a_start_together: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> (state_reg == S_MUL) && (cstate_reg == U_CNT))
        else $error("speed and count paths did not start together");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        d1_start |-> !d1_stat.busy)
        else $error("speed divider restarted while busy");

    a_query_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) && !is_edge
        |=> (speed_reg == $past(speed_reg)) || (speed_reg == '0))
        else $error("query changed speed to a nonzero value");

    a_edge_interp: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && is_edge |-> interp_reg == '0)
        else $error("edge result carries an interpolation term");

endmodule

`default_nettype wire

@@ tb/tb_spindle_encoder_speed_angle.sv @@
// tb_spindle_encoder_speed_angle: self-checking bench for the spindle tachometer and
// angle estimator; a directed table, then encoder-like random motion under several ratios
// depends on seas_pkg, seas_in_if, seas_out_if and spindle_encoder_speed_angle
`timescale 1ns / 1ps

module tb_spindle_encoder_speed_angle;
    import seas_pkg::*;

    localparam int          SETTLE_CYCLES  = 120;
    localparam int          RX_HOLD_CYCLES = 600;
    localparam int          PHASES         = 8;
    localparam int          PHASE_ITEMS    = 150;
    localparam logic [63:0] RPM_US         = 64'd60000000;
    localparam logic [63:0] STALL_US       = 64'd2000000;
    localparam logic [63:0] CDEG_REV       = 64'd36000;
    localparam logic [63:0] CDEG_DIV       = 64'd5000;
    // index that decodes to no register
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(1);

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [REV_W-1:0]   revs;
        logic [ANGLE_W-1:0] angle;
    } reading_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] t;
        bit                fixed;
        reading_t          want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    seas_in_if  item_ch ();
    seas_out_if res_ch ();

    spindle_encoder_speed_angle dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // tachometer state as the bench sees it
    logic [EPR_W-1:0]   tb_epr        = EPR_RESET;
    logic [COUNT_W-1:0] tb_edge_count = '0;
    logic [TIME_W-1:0]  tb_last_edge  = '0;
    logic [SPEED_W-1:0] tb_speed      = '0;

    reading_t expected_q [$];
    dir_row_t dir_rows [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_ack    = 0;
    int hold_left   = 0;
    int errors      = 0;
    int items_sent  = 0;
    int results_seen = 0;
    int cfg_writes  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("timeout at %0t with %0d results outstanding", $time, expected_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    // advance the tachometer by one item and produce the reading it reports
    task automatic tach_step(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                             output reading_t r);
        logic [EPR_W-1:0]   eff;
        logic [TIME_W-1:0]  dt;
        logic [COUNT_W-1:0] revs;
        logic [63:0]        denom;
        logic [63:0]        q;
        logic [63:0]        base;
        logic [63:0]        interp;
        eff = (tb_epr == '0) ? EPR_W'(1) : tb_epr;
        dt  = now - tb_last_edge;
        if (op == OP_EDGE)
        begin
            denom = 64'(eff) * 64'(dt);
            tb_edge_count = tb_edge_count + 1'b1;
            if (denom == 64'd0)
            begin
                tb_speed = SPEED_MAX;
            end
            else
            begin
                q = RPM_US / denom;
                tb_speed = (q > 64'(SPEED_MAX)) ? SPEED_MAX : q[SPEED_W-1:0];
            end
            tb_last_edge = now;
        end
        else if (64'(dt) > STALL_US / 64'(eff))
        begin
            tb_speed = '0;
        end
        dt     = now - tb_last_edge;
        base   = (CDEG_REV * 64'(tb_edge_count)) / 64'(eff);
        interp = (64'd3 * 64'(tb_speed) * 64'(dt)) / CDEG_DIV;
        revs   = tb_edge_count / COUNT_W'(eff);
        r.speed = tb_speed;
        r.revs  = revs[REV_W-1:0];
        r.angle = base[ANGLE_W-1:0] + interp[ANGLE_W-1:0];
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                             input bit fixed, input reading_t want);
        reading_t pred;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.op      <= op;
        item_ch.time_us <= t;
        do
            @(posedge clk);
        while (!item_ch.ready);
        tach_step(op, t, pred);
        expected_q.push_back(fixed ? want : pred);
        items_sent++;
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_EPR)
        begin
            tb_epr = data[EPR_W-1:0];
        end
        cfg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // let every outstanding result come back, then give the block time to settle
    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                           input bit fixed, input int spd, input int revs, input longint ang);
        dir_row_t row;
        row.op         = op;
        row.t          = t;
        row.fixed      = fixed;
        row.want.speed = SPEED_W'(spd);
        row.want.revs  = REV_W'(revs);
        row.want.angle = ANGLE_W'(ang);
        dir_rows.push_back(row);
    endtask

    // receiver: random backpressure plus one long hold
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result speed %0d revs %0d angle %0d", $time,
                         res_ch.speed_rpm, res_ch.revolutions, res_ch.angle_cdeg);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                results_seen++;
                if (res_ch.speed_rpm !== want.speed)
                begin
                    $display("%0t: speed_rpm expected %0d got %0d", $time,
                             want.speed, res_ch.speed_rpm);
                    errors++;
                end
                if (res_ch.revolutions !== want.revs)
                begin
                    $display("%0t: revolutions expected %0d got %0d", $time,
                             want.revs, res_ch.revolutions);
                    errors++;
                end
                if (res_ch.angle_cdeg !== want.angle)
                begin
                    $display("%0t: angle_cdeg expected %0d got %0d", $time,
                             want.angle, res_ch.angle_cdeg);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] jitter;
        logic [TIME_W-1:0] off;
        logic [TIME_W-1:0] stall;
        logic [DATA_W-1:0] cfg;
        logic [EPR_W-1:0]  eff;
        reading_t          none;
        int                burst_left;
        int                roll;

        none            = '0;
        burst_left      = 0;
        period          = 32'd1000;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.op      = OP_EDGE;
        item_ch.time_us = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset setting of one edge per revolution
        add_row(OP_QUERY, 32'd0,          1, 0,     0, 0);
        add_row(OP_EDGE,  32'd0,          1, 32767, 1, 36000);      // zero interval
        add_row(OP_QUERY, 32'd0,          1, 32767, 1, 36000);
        add_row(OP_QUERY, 32'd5000,       1, 32767, 1, 134301);
        add_row(OP_QUERY, 32'd2000001,    1, 0,     1, 36000);      // just past stall
        add_row(OP_EDGE,  32'hFFFF_FFFF,  1, 0,     2, 72000);      // longest interval
        add_row(OP_EDGE,  32'd0,          1, 32767, 3, 108000);     // wrap, one us
        add_row(OP_EDGE,  32'd1000,       1, 32767, 4, 144000);     // saturates
        add_row(OP_EDGE,  32'd61000,      1, 1000,  5, 180000);
        add_row(OP_QUERY, 32'd66000,      1, 1000,  5, 183000);
        add_row(OP_QUERY, 32'd2061000,    1, 1000,  5, 1380000);    // exactly at stall
        add_row(OP_QUERY, 32'd2061001,    1, 0,     5, 180000);
        add_row(OP_EDGE,  32'd2062831,    0, 0,     0, 0);
        add_row(OP_EDGE,  32'd2062838,    0, 0,     0, 0);
        add_row(OP_QUERY, 32'd2062837,    0, 0,     0, 0);          // far past stall
        add_row(OP_EDGE,  32'h8000_0000,  0, 0,     0, 0);
        add_row(OP_EDGE,  32'h8000_3039,  0, 0,     0, 0);
        add_row(OP_QUERY, 32'h8000_303A,  0, 0,     0, 0);
        add_row(OP_QUERY, 32'hFFFF_FFFF,  0, 0,     0, 0);
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].op, dir_rows[i].t, dir_rows[i].fixed, dir_rows[i].want);
        end
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: cfg = 32'd0;                             // treated as one
                1: cfg = 32'd2047;
                2: cfg = 32'd1024;
                3: cfg = 32'd1;
                4: cfg = 32'hFFFF_F803;                     // junk above the field
                5: cfg = DATA_W'($urandom_range(1, 1024));
                6: cfg = DATA_W'($urandom_range(2, 16));
                default: cfg = 32'd1024;
            endcase
            if (ph == 3)
            begin
                apb_write(REG_SPARE, 32'd7);
            end
            apb_write(REG_EPR, cfg);
            if (ph < 3)
            begin
                tx_idle_pct = 37;
                rx_idle_pct = 68;
            end
            else if (ph < 6)
            begin
                tx_idle_pct = 68;
                rx_idle_pct = 37;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (ph == 6)
            begin
                hold_req++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                eff   = (tb_epr == '0) ? EPR_W'(1) : tb_epr;
                stall = TIME_W'(STALL_US / 64'(eff));
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(8, 30);
                    case ($urandom_range(0, 4))
                        0: period = $urandom_range(0, 3);
                        1: period = $urandom_range(1, 3000);
                        2: period = $urandom_range(2000, 300000);
                        3: period = $urandom_range(stall / 2, stall * 2 + 1);
                        default: period = $urandom;
                    endcase
                end
                burst_left--;
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    op = OP_W'($urandom_range(0, 1));
                    t  = $urandom;
                end
                else if (roll < 70)
                begin
                    op     = OP_EDGE;
                    jitter = period / 16;
                    t      = tb_last_edge + period - jitter + $urandom_range(0, 2 * jitter);
                end
                else
                begin
                    op = OP_QUERY;
                    case ($urandom_range(0, 3))
                        0: off = stall;
                        1: off = stall + 1;
                        default: off = $urandom_range(0, period) + $urandom_range(0, period);
                    endcase
                    t = tb_last_edge + off;
                end
                send_item(op, t, 0, none);
            end
            drain();
        end

        $display("%0d items over %0d register writes, %0d results checked", items_sent,
                 cfg_writes, results_seen);
        $display("edges_per_rev covered 0, 1, 1024, 2047 and random; long receiver hold once");
        if (errors == 0 && expected_q.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
